[rtl/rplp_pkg.sv]
// ----------------------------------------------------------------------------
// rplp_pkg: shared types and constants for the integer literal parser
// Character codes, radix and error codes, and the beat types that pass
// between the parser's stages.
// ----------------------------------------------------------------------------
package rplp_pkg;

  // Width of the accumulator; results are taken modulo 2^VALUE_WIDTH.
  localparam int VALUE_WIDTH = 64;
  localparam int OUT_WIDTH   = 64;

  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_F  = 8'h46;
  localparam logic [7:0] CH_UP_B  = 8'h42;
  localparam logic [7:0] CH_UP_X  = 8'h58;
  localparam logic [7:0] CH_LO_B  = 8'h62;
  localparam logic [7:0] CH_LO_X  = 8'h78;

  localparam logic [4:0] RADIX_2  = 5'd2;
  localparam logic [4:0] RADIX_8  = 5'd8;
  localparam logic [4:0] RADIX_10 = 5'd10;
  localparam logic [4:0] RADIX_16 = 5'd16;

  // Digit value that no radix accepts.
  localparam logic [4:0] DIGIT_NONE = 5'd16;

  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_NOT_DIGIT = 2'd1;
  localparam logic [1:0] ERR_PREFIX    = 2'd2;
  localparam logic [1:0] ERR_DIGIT     = 2'd3;

  // One character beat held in the input register.
  typedef struct packed {
    logic       valid;
    logic [7:0] character;
    logic       last_char;
  } item_t;

  // One result beat headed for the output register.
  typedef struct packed {
    logic                   valid;
    logic [OUT_WIDTH-1:0]   value;
    logic [1:0]             error;
  } result_t;

  // Value of a character as a digit in base 16 or lower, DIGIT_NONE otherwise.
  function automatic logic [4:0] digit_of(input logic [7:0] c);
    logic [7:0] diff;
    begin
      diff = 8'h00;
      if (c >= CH_0 && c <= CH_9) begin
        diff = 8'(c - CH_0);
        digit_of = {1'b0, diff[3:0]};
      end else if (c >= CH_UP_A && c <= CH_UP_F) begin
        diff = 8'(c - CH_UP_A + 8'd10);
        digit_of = {1'b0, diff[3:0]};
      end else begin
        digit_of = DIGIT_NONE;
      end
    end
  endfunction

endpackage

[rtl/radix_prefixed_literal_parser.sv]
// ----------------------------------------------------------------------------
// radix_prefixed_literal_parser: C-style integer literal parser
// Reads a number token one character per beat and returns its value and
// an error code on the beat that carries the token's last character.
// ----------------------------------------------------------------------------
// The parser takes one ASCII character beat every clock cycle unless stalled,
// with no gaps needed between characters or between tokens. Each character
// passes through an input register, a single pass of update logic on the
// token state, and a result register, so the result beat of a token is
// loaded into the result register from the update of its last character
// and held there until the receiver takes it. A token starts with a decimal
// digit; "0x"/"0X" selects hex (uppercase letters A to F only), "0b"/"0B"
// selects binary, a zero followed by a digit selects octal, a lone zero is
// zero, and anything else is decimal. The value wraps modulo 2^VALUE_WIDTH
// and reads as zero whenever the error code is not zero. Error codes: one
// when the token does not start with a digit, two for a bad prefix after a
// leading zero, three for a character that is not a digit of the chosen
// base. The first error of a token is kept and the rest of the token is
// skipped. Beats that do not end a token produce no result. The multiply by
// the radix is built from shifts and one add. Output stall backs up into
// the input stall within the same cycle once the input register is full.
module radix_prefixed_literal_parser (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     character,
  input  logic                           last_char,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [rplp_pkg::OUT_WIDTH-1:0] value,
  output logic [1:0]                     error
);
  import rplp_pkg::*;

  // Character beat waiting in the input register.
  item_t   item;
  // Result of the current character, valid only at the end of a token.
  result_t result;
  // High when the result register can take a new beat this cycle.
  logic    advance;

  rplp_in_stage u_in (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .character (character),
    .last_char (last_char),
    .advance   (advance),
    .item      (item)
  );

  rplp_core u_core (
    .clk     (clk),
    .rst     (rst),
    .item    (item),
    .advance (advance),
    .result  (result)
  );

  rplp_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .result    (result),
    .advance   (advance),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .value     (value),
    .error     (error)
  );

endmodule

[rtl/rplp_in_stage.sv]
// ----------------------------------------------------------------------------
// rplp_in_stage: input register of the literal parser
// Captures one character beat and holds it until the core consumes it.
// ----------------------------------------------------------------------------
module rplp_in_stage (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [7:0]      character,
  input  logic            last_char,
  input  logic            advance,
  output rplp_pkg::item_t item
);
  import rplp_pkg::*;

  item_t held;

  // The held beat leaves only when the stage behind can move.
  assign in_stall = held.valid && !advance;
  assign item     = held;

  always_ff @(posedge clk) begin
    if (rst) begin
      held.valid <= 1'b0;
    end else if (!held.valid || advance) begin
      held.valid <= in_valid;
    end
    if (in_valid && !in_stall) begin
      held.character <= character;
      held.last_char <= last_char;
    end
  end

endmodule

[rtl/rplp_core.sv]
// ----------------------------------------------------------------------------
// rplp_core: token state and per-character update of the literal parser
// Holds phase, radix, accumulator and error code, and works out one
// character in a single pass.
// ----------------------------------------------------------------------------
module rplp_core (
  input  logic              clk,
  input  logic              rst,
  input  rplp_pkg::item_t   item,
  input  logic              advance,
  output rplp_pkg::result_t result
);
  import rplp_pkg::*;

  typedef enum logic [2:0] {
    PH_START  = 3'd0,
    PH_ZERO   = 3'd1,
    PH_DIGITS = 3'd2,
    PH_ERROR  = 3'd3
  } phase_t;

  phase_t                 phase, phase_next;
  logic [4:0]             radix, radix_next;
  logic [VALUE_WIDTH-1:0] acc, acc_next;
  logic [1:0]             error_code, error_code_next;

  logic                   is_dec;
  logic [4:0]             digit;
  logic [4:0]             use_radix;
  logic [VALUE_WIDTH-1:0] scaled;
  logic [VALUE_WIDTH-1:0] acc_added;
  logic                   fire;

  assign fire   = item.valid && advance;
  assign is_dec = (item.character >= CH_0) && (item.character <= CH_9);
  assign digit  = digit_of(item.character);

  // The first octal digit follows the leading zero, where acc is still zero.
  assign use_radix = (phase == PH_ZERO) ? RADIX_8 : radix;

  // Multiplication by the radix as shifts and one add.
  always_comb begin
    unique case (use_radix)
      RADIX_2:  scaled = acc << 1;
      RADIX_8:  scaled = acc << 3;
      RADIX_10: scaled = (acc << 3) + (acc << 1);
      RADIX_16: scaled = acc << 4;
      default:  scaled = '0;
    endcase
  end

  assign acc_added = scaled + VALUE_WIDTH'(digit);

  always_comb begin
    phase_next      = phase;
    radix_next      = radix;
    acc_next        = acc;
    error_code_next = error_code;
    unique case (phase)
      PH_START: begin
        if (!is_dec) begin
          error_code_next = ERR_NOT_DIGIT;
          phase_next      = PH_ERROR;
        end else if (item.character == CH_0) begin
          phase_next = PH_ZERO;
        end else begin
          radix_next = RADIX_10;
          acc_next   = VALUE_WIDTH'(digit);
          phase_next = PH_DIGITS;
        end
      end
      PH_ZERO: begin
        if (item.character == CH_LO_X || item.character == CH_UP_X) begin
          radix_next = RADIX_16;
          phase_next = PH_DIGITS;
        end else if (item.character == CH_LO_B || item.character == CH_UP_B) begin
          radix_next = RADIX_2;
          phase_next = PH_DIGITS;
        end else if (is_dec) begin
          radix_next = RADIX_8;
          if (digit >= RADIX_8) begin
            error_code_next = ERR_DIGIT;
            phase_next      = PH_ERROR;
          end else begin
            acc_next   = acc_added;
            phase_next = PH_DIGITS;
          end
        end else begin
          error_code_next = ERR_PREFIX;
          phase_next      = PH_ERROR;
        end
      end
      PH_DIGITS: begin
        if (digit >= radix) begin
          error_code_next = ERR_DIGIT;
          phase_next      = PH_ERROR;
        end else begin
          acc_next = acc_added;
        end
      end
      PH_ERROR: begin
      end
      default: begin
        phase_next = PH_ERROR;
      end
    endcase
  end

  assign result.valid = fire && item.last_char;
  assign result.value = (error_code_next == ERR_NONE) ? OUT_WIDTH'(acc_next) : '0;
  assign result.error = error_code_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_START;
      radix      <= RADIX_10;
      acc        <= '0;
      error_code <= ERR_NONE;
    end else if (fire) begin
      if (item.last_char) begin
        phase      <= PH_START;
        radix      <= RADIX_10;
        acc        <= '0;
        error_code <= ERR_NONE;
      end else begin
        phase      <= phase_next;
        radix      <= radix_next;
        acc        <= acc_next;
        error_code <= error_code_next;
      end
    end
  end

endmodule

[rtl/rplp_out_stage.sv]
// ----------------------------------------------------------------------------
// rplp_out_stage: result register of the literal parser
// Holds one result beat until the receiver takes it.
// ----------------------------------------------------------------------------
module rplp_out_stage (
  input  logic                           clk,
  input  logic                           rst,
  input  rplp_pkg::result_t              result,
  output logic                           advance,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [rplp_pkg::OUT_WIDTH-1:0] value,
  output logic [1:0]                     error
);
  import rplp_pkg::*;

  // The pipeline moves whenever the result register is empty or drains.
  assign advance = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= result.valid;
    end
    if (advance && result.valid) begin
      value <= result.value;
      error <= result.error;
    end
  end

endmodule

[rtl/rplp_checker.sv]
// ----------------------------------------------------------------------------
// rplp_checker: port-level assertions for the literal parser
// Watches the top level's ports and is attached to it by a bind.
// ----------------------------------------------------------------------------
module rplp_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic [7:0]                     character,
  input logic                           last_char,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [rplp_pkg::OUT_WIDTH-1:0] value,
  input logic [1:0]                     error
);
  import rplp_pkg::*;

  // No result beat comes out of reset.
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result beat right after reset");

  // A stalled result beat holds its value and error code.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(value) && $stable(error))
    else $error("stalled result beat changed");

  // An error result always carries a zero value.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && error != ERR_NONE |-> value == '0)
    else $error("error result with nonzero value");

  // The input only backs up while a result beat is held by the receiver.
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output back-pressure");

endmodule

bind radix_prefixed_literal_parser rplp_checker u_rplp_checker (.*);
